FILE: rtl/md5s_pkg.sv
// Package: MD5 stream hasher types, microcode codes, round tables and helpers.
package md5s_pkg;

    localparam int unsigned STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // microprogram step addresses
    localparam step_t ST_IDLE   = 4'd0;
    localparam step_t ST_CHK    = 4'd1;
    localparam step_t ST_PAD    = 4'd2;
    localparam step_t ST_ZERO   = 4'd3;
    localparam step_t ST_LENLO  = 4'd4;
    localparam step_t ST_LENHI  = 4'd5;
    localparam step_t ST_EMIT   = 4'd6;
    localparam step_t ST_CLOAD  = 4'd7;
    localparam step_t ST_CROUND = 4'd8;
    localparam step_t ST_CFINAL = 4'd9;

    typedef logic [2:0] wr_op_t;
    localparam wr_op_t W_NONE  = 3'd0;
    localparam wr_op_t W_IN    = 3'd1;
    localparam wr_op_t W_PAD   = 3'd2;
    localparam wr_op_t W_ZERO  = 3'd3;
    localparam wr_op_t W_LENLO = 3'd4;
    localparam wr_op_t W_LENHI = 3'd5;

    typedef logic [1:0] cp_op_t;
    localparam cp_op_t CP_NONE  = 2'd0;
    localparam cp_op_t CP_LOAD  = 2'd1;
    localparam cp_op_t CP_ROUND = 2'd2;
    localparam cp_op_t CP_FINAL = 2'd3;

    typedef logic [3:0] jmp_t;
    localparam jmp_t J_NEXT = 4'd0;
    localparam jmp_t J_GOTO = 4'd1;
    localparam jmp_t J_CALL = 4'd2;
    localparam jmp_t J_RET  = 4'd3;
    localparam jmp_t J_IDLE = 4'd4;
    localparam jmp_t J_CHK  = 4'd5;
    localparam jmp_t J_PAD  = 4'd6;
    localparam jmp_t J_ZERO = 4'd7;
    localparam jmp_t J_LOOP = 4'd8;
    localparam jmp_t J_WAIT = 4'd9;

    typedef struct packed {
        logic   ready;
        wr_op_t wr_op;
        cp_op_t cp_op;
        logic   emit;
        jmp_t   jmp;
        step_t  target;
        step_t  ret;
    } uword_t;

    typedef struct packed {
        logic accept;
        logic has_byte;
        logic in_last;
        logic last_seen;
        logic ptr_end;
        logic ptr_len;
        logic round_end;
        logic out_free;
    } cond_t;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;
    localparam logic [5:0]  BLK_END  = 6'd63;
    localparam logic [3:0]  LEN_WORD_LO = 4'd14;
    localparam logic [3:0]  LEN_WORD_HI = 4'd15;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // message word index used by round i
    function automatic logic [3:0] word_index(input logic [5:0] i);
        logic [3:0] j;
        logic [3:0] g;
        j = i[3:0];
        case (i[5:4])
            2'd0:    g = j;
            2'd1:    g = j * 4'd5 + 4'd1;
            2'd2:    g = j * 4'd3 + 4'd5;
            2'd3:    g = j * 4'd7;
            default: g = j;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [5:0] rs;
        rs = 6'd32 - {1'b0, s};
        return (x << s) | (x >> rs);
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

FILE: rtl/md5s_if.sv
// Interfaces: message byte channel and digest channel.
interface md5s_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;

    modport source (output valid, data_byte, has_byte, is_last, input ready);
    modport sink   (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface md5s_dig_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_first_half;
    logic [63:0] digest_second_half;
    logic [63:0] half_mix;

    modport source (output valid, digest_first_half, digest_second_half, half_mix,
                    input ready);
    modport sink   (input valid, digest_first_half, digest_second_half, half_mix,
                    output ready);
endinterface

FILE: rtl/md5s_sequencer.sv
// Microcode sequencer: control store, step counter, return register, jumps.
module md5s_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  md5s_pkg::cond_t  cond,
    output md5s_pkg::uword_t uw
);
    import md5s_pkg::*;

    step_t pc_reg;
    step_t pc_next;
    step_t ret_reg;
    step_t ret_next;

    function automatic uword_t ucode(input step_t pc);
        uword_t w;
        w = '{ready: 1'b0, wr_op: W_NONE, cp_op: CP_NONE, emit: 1'b0,
              jmp: J_GOTO, target: ST_IDLE, ret: ST_IDLE};
        case (pc)
            ST_IDLE:
            begin
                w.ready  = 1'b1;
                w.wr_op  = W_IN;
                w.jmp    = J_IDLE;
                w.target = ST_PAD;
                w.ret    = ST_CHK;
            end
            ST_CHK:
            begin
                w.jmp    = J_CHK;
                w.target = ST_PAD;
            end
            ST_PAD:
            begin
                w.wr_op  = W_PAD;
                w.jmp    = J_PAD;
                w.target = ST_ZERO;
                w.ret    = ST_ZERO;
            end
            ST_ZERO:
            begin
                w.wr_op  = W_ZERO;
                w.jmp    = J_ZERO;
                w.target = ST_LENLO;
                w.ret    = ST_ZERO;
            end
            ST_LENLO:
            begin
                w.wr_op = W_LENLO;
                w.jmp   = J_NEXT;
            end
            ST_LENHI:
            begin
                w.wr_op  = W_LENHI;
                w.jmp    = J_CALL;
                w.target = ST_CLOAD;
                w.ret    = ST_EMIT;
            end
            ST_EMIT:
            begin
                w.emit   = 1'b1;
                w.jmp    = J_WAIT;
                w.target = ST_IDLE;
            end
            ST_CLOAD:
            begin
                w.cp_op = CP_LOAD;
                w.jmp   = J_NEXT;
            end
            ST_CROUND:
            begin
                w.cp_op = CP_ROUND;
                w.jmp   = J_LOOP;
            end
            ST_CFINAL:
            begin
                w.cp_op = CP_FINAL;
                w.jmp   = J_RET;
            end
            default:
            begin
                w.jmp    = J_GOTO;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    assign uw = ucode(pc_reg);

    always_comb
    begin
        pc_next  = pc_reg;
        ret_next = ret_reg;
        case (uw.jmp)
            J_NEXT: pc_next = pc_reg + 1'b1;
            J_GOTO: pc_next = uw.target;
            J_CALL:
            begin
                pc_next  = uw.target;
                ret_next = uw.ret;
            end
            J_RET:  pc_next = ret_reg;
            J_IDLE:
            begin
                if (cond.accept)
                begin
                    if (cond.has_byte && cond.ptr_end)
                    begin
                        pc_next  = ST_CLOAD;
                        ret_next = uw.ret;
                    end
                    else if (cond.in_last)
                    begin
                        pc_next = uw.target;
                    end
                end
            end
            J_CHK:  pc_next = cond.last_seen ? uw.target : ST_IDLE;
            J_PAD:
            begin
                if (cond.ptr_end)
                begin
                    pc_next  = ST_CLOAD;
                    ret_next = uw.ret;
                end
                else
                begin
                    pc_next = uw.target;
                end
            end
            J_ZERO:
            begin
                if (cond.ptr_len)
                begin
                    pc_next = uw.target;
                end
                else if (cond.ptr_end)
                begin
                    pc_next  = ST_CLOAD;
                    ret_next = uw.ret;
                end
            end
            J_LOOP: pc_next = cond.round_end ? pc_reg + 1'b1 : pc_reg;
            J_WAIT: pc_next = cond.out_free ? uw.target : pc_reg;
            default: pc_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= ST_IDLE;
            ret_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg  <= pc_next;
            ret_reg <= ret_next;
        end
    end

endmodule

FILE: rtl/md5_stream_hasher_top.sv
// Top level: MD5 stream hasher with microcoded control and one-round-per-cycle datapath.
//
//  channel | dir | payload                                             | accepted when
//  msg     | in  | data_byte[7:0], has_byte, is_last                   | valid && ready
//  dig     | out | digest_first_half, digest_second_half, half_mix     | valid && ready
//
// The byte that completes a 64-byte block starts a compression (load, 64 rounds, final add,
// check). A last item pads byte by byte, writes the length as two words and runs one or two
// compressions; the 16-word block buffer's single read port sets the round rate.
// The digest sits in an output register; the hasher takes new bytes while it waits, and
// stalls for output only when a second digest is ready before the first is taken.
// Reset restores the MD5 IV.
module md5_stream_hasher_top (
    input logic        clk,
    input logic        rst_n,
    md5s_msg_if.sink   msg,
    md5s_dig_if.source dig
);
    import md5s_pkg::*;

    uword_t uw;
    cond_t  cond;

    logic        accept;
    logic        out_free;
    logic        emit_go;
    logic        we_b;
    logic        we_w;
    logic [7:0]  wb;
    logic [3:0]  waddr;
    logic [31:0] ww;
    logic [3:0]  raddr;
    logic [5:0]  rd_round;
    logic [63:0] bit_len;
    logic [31:0] f;
    logic [31:0] t;

    logic [3:0][7:0] buf_mem [16];
    logic [31:0] rdata_reg;

    logic [5:0]  ptr_reg;
    logic [60:0] cnt_reg;
    logic        last_reg;
    logic [5:0]  round_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] h0_reg, h1_reg, h2_reg, h3_reg;
    logic        out_valid_reg;
    logic [63:0] first_reg, second_reg, mix_reg;

    assign accept    = msg.valid && msg.ready;
    assign msg.ready = uw.ready;
    assign out_free  = !out_valid_reg || dig.ready;
    assign emit_go   = uw.emit && out_free;
    assign bit_len   = {cnt_reg, 3'b000};

    assign cond.accept    = accept;
    assign cond.has_byte  = msg.has_byte;
    assign cond.in_last   = msg.is_last;
    assign cond.last_seen = last_reg;
    assign cond.ptr_end   = (ptr_reg == BLK_END);
    assign cond.ptr_len   = (ptr_reg == LEN_POS);
    assign cond.round_end = (round_reg == BLK_END);
    assign cond.out_free  = out_free;

    md5s_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .uw    (uw)
    );

    // buffer write selection
    always_comb
    begin
        we_b  = 1'b0;
        we_w  = 1'b0;
        wb    = 8'h00;
        waddr = LEN_WORD_LO;
        ww    = bit_len[31:0];
        case (uw.wr_op)
            W_IN:
            begin
                we_b = accept && msg.has_byte;
                wb   = msg.data_byte;
            end
            W_PAD:
            begin
                we_b = 1'b1;
                wb   = PAD_BYTE;
            end
            W_ZERO:  we_b = !cond.ptr_len;
            W_LENLO: we_w = 1'b1;
            W_LENHI:
            begin
                we_w  = 1'b1;
                waddr = LEN_WORD_HI;
                ww    = bit_len[63:32];
            end
            default: we_b = 1'b0;
        endcase
    end

    assign rd_round = (uw.cp_op == CP_LOAD) ? 6'd0 : round_reg + 6'd1;
    assign raddr    = word_index(rd_round);

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            buf_mem[ptr_reg[5:2]][ptr_reg[1:0]] <= wb;
        end
        if (we_w)
        begin
            buf_mem[waddr] <= ww;
        end
        rdata_reg <= buf_mem[raddr];
    end

    always_comb
    begin
        case (round_reg[5:4])
            2'd0:    f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f = b_reg ^ c_reg ^ d_reg;
            2'd3:    f = c_reg ^ (b_reg | ~d_reg);
            default: f = b_reg ^ c_reg ^ d_reg;
        endcase
    end

    assign t = a_reg + f + round_k(round_reg) + rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            round_reg <= '0;
            h0_reg    <= IV_A;
            h1_reg    <= IV_B;
            h2_reg    <= IV_C;
            h3_reg    <= IV_D;
        end
        else
        begin
            if (accept)
            begin
                last_reg <= msg.is_last;
            end
            if (we_b)
            begin
                ptr_reg <= ptr_reg + 6'd1;
            end
            if (uw.wr_op == W_IN && we_b)
            begin
                cnt_reg <= cnt_reg + 61'd1;
            end
            case (uw.cp_op)
                CP_LOAD:  round_reg <= '0;
                CP_ROUND: round_reg <= round_reg + 6'd1;
                CP_FINAL:
                begin
                    h0_reg <= h0_reg + a_reg;
                    h1_reg <= h1_reg + b_reg;
                    h2_reg <= h2_reg + c_reg;
                    h3_reg <= h3_reg + d_reg;
                end
                default: round_reg <= round_reg;
            endcase
            if (emit_go)
            begin
                ptr_reg <= '0;
                cnt_reg <= '0;
                h0_reg  <= IV_A;
                h1_reg  <= IV_B;
                h2_reg  <= IV_C;
                h3_reg  <= IV_D;
            end
        end
    end

    // working variables
    always_ff @(posedge clk)
    begin
        if (uw.cp_op == CP_LOAD)
        begin
            a_reg <= h0_reg;
            b_reg <= h1_reg;
            c_reg <= h2_reg;
            d_reg <= h3_reg;
        end
        else if (uw.cp_op == CP_ROUND)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rotl32(t, round_s(round_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dig.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            first_reg  <= {bswap32(h0_reg), bswap32(h1_reg)};
            second_reg <= {bswap32(h2_reg), bswap32(h3_reg)};
            mix_reg    <= {bswap32(h1_reg ^ h3_reg), bswap32(h0_reg ^ h2_reg)};
        end
    end

    assign dig.valid              = out_valid_reg;
    assign dig.digest_first_half  = first_reg;
    assign dig.digest_second_half = second_reg;
    assign dig.half_mix           = mix_reg;

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.cp_op != CP_NONE) |-> !msg.ready)
        else $error("input ready during compression");

    a_final_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.cp_op == CP_FINAL) |-> (round_reg == 6'd0) && ($past(uw.cp_op) == CP_ROUND))
        else $error("final add without full round sequence");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> (ptr_reg == 6'd0) && (cnt_reg == 61'd0) && dig.valid)
        else $error("digest emitted without restart of message state");

    a_len_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.wr_op == W_LENLO) |-> cond.ptr_len)
        else $error("length written at unaligned pointer");

endmodule

FILE: tb/md5_stream_hasher_top_tb.sv
// Testbench for md5_stream_hasher_top: byte-stream messages checked against a digest predictor.
`timescale 1ns / 100ps

module md5_stream_hasher_top_tb;

    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_ITEMS   = 200;
    localparam int PHASE_DIGESTS = 3;

    localparam logic [0:63][31:0] SINE_ADD = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [0:15][4:0] ROT_AMT = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic [63:0] first_half;
        logic [63:0] second_half;
        logic [63:0] half_mix;
    } digest_t;

    logic clk;
    logic rst_n;

    md5s_msg_if msg_ch();
    md5s_dig_if dig_ch();

    md5_stream_hasher_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_ch),
        .dig   (dig_ch)
    );

    // predictor state
    logic [31:0] chain_words [4];
    logic [7:0]  block_bytes [64];
    logic [5:0]  block_fill;
    logic [60:0] msg_length;

    digest_t pending_digests [$];

    int errors;
    int src_idle_pct;
    int snk_idle_pct;
    int hold_left;
    int items_sent;
    int bytes_hashed;
    int messages_sent;
    int digests_checked;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void md5_restart();
        chain_words[0] = 32'h67452301;
        chain_words[1] = 32'hefcdab89;
        chain_words[2] = 32'h98badcfe;
        chain_words[3] = 32'h10325476;
        for (int k = 0; k < 64; k++)
            block_bytes[k] = 8'h00;
        block_fill = '0;
        msg_length = '0;
    endfunction

    function automatic void block_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        logic [4:0]  sh;
        int          g;
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        for (int k = 0; k < 16; k++)
            w[k] = {block_bytes[4*k+3], block_bytes[4*k+2], block_bytes[4*k+1], block_bytes[4*k]};
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (d & b) | (~d & c);
                    g = (5 * i + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            t  = a + f + SINE_ADD[i] + w[g];
            sh = ROT_AMT[(i / 16) * 4 + (i % 4)];
            a  = d;
            d  = c;
            c  = b;
            b  = b + ((t << sh) | (t >> (32 - sh)));
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
    endfunction

    // updates the predictor for one accepted item; returns 1 when a digest is due
    function automatic bit md5_absorb(input logic [7:0] data, input bit has_data, input bit last,
                                      output digest_t dg);
        logic [7:0]  dbytes [16];
        logic [63:0] bit_len;
        logic [7:0]  x;
        int          pos;
        dg = '0;
        if (has_data)
        begin
            block_bytes[block_fill] = data;
            block_fill = block_fill + 6'd1;
            msg_length = msg_length + 61'd1;
            if (block_fill == 6'd0)
                block_compress();
        end
        if (!last)
            return 1'b0;
        pos = int'(block_fill);
        block_bytes[pos] = 8'h80;
        pos++;
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            block_compress();
            pos = 0;
        end
        while (pos < 56)
        begin
            block_bytes[pos] = 8'h00;
            pos++;
        end
        bit_len = {msg_length, 3'b000};
        for (int k = 0; k < 8; k++)
            block_bytes[56 + k] = bit_len[8*k +: 8];
        block_compress();
        for (int k = 0; k < 16; k++)
            dbytes[k] = chain_words[k / 4][8*(k % 4) +: 8];
        for (int k = 0; k < 8; k++)
        begin
            dg.first_half  = {dg.first_half[55:0], dbytes[k]};
            dg.second_half = {dg.second_half[55:0], dbytes[k + 8]};
        end
        for (int k = 0; k < 4; k++)
        begin
            x = dbytes[k] ^ dbytes[k + 8];
            dg.half_mix[8*(3 - k) +: 8] = x;
            x = dbytes[k + 4] ^ dbytes[k + 12];
            dg.half_mix[32 + 8*(3 - k) +: 8] = x;
        end
        md5_restart();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < 30)
            $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_item(input logic [7:0] data, input bit has_data, input bit last);
        digest_t dg;
        while ($urandom_range(99) < src_idle_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid     <= 1'b1;
        msg_ch.data_byte <= data;
        msg_ch.has_byte  <= has_data;
        msg_ch.is_last   <= last;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        if (md5_absorb(data, has_data, last, dg))
        begin
            pending_digests.push_back(dg);
            messages_sent++;
        end
        items_sent++;
        if (has_data)
            bytes_hashed++;
    endtask

    task automatic finish_sending();
        msg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        msg_ch.valid <= 1'b0;
        while (pending_digests.size() != 0)
            @(posedge clk);
    endtask

    // random bytes, occasional ignored items, last either on the final byte or on its own
    task automatic hash_random_message(input int len);
        bit split_last;
        split_last = 1'($urandom_range(1));
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(99) < 6)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, (k == len - 1) && !split_last);
        end
        if (len == 0 || split_last)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic test_directed_cases();
        // empty message, data ignored
        send_item(8'hA5, 1'b0, 1'b1);
        // "abc", last rides on the final byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // extremes with an ignored item between, then a bare last
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // single-byte message
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hFE, 1'b1, 1'b1);
        send_item(8'h55, 1'b0, 1'b1);
        send_item(8'hAA, 1'b1, 1'b0);
        send_item(8'h33, 1'b0, 1'b0);
        send_item(8'hCC, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_messages(input int src_pct, input int snk_pct);
        int start_items;
        int start_msgs;
        int r;
        int len;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        start_items  = items_sent;
        start_msgs   = messages_sent;
        while (items_sent - start_items < PHASE_ITEMS || messages_sent - start_msgs < PHASE_DIGESTS)
        begin
            r = $urandom_range(99);
            // favor short messages and the one/two-compression padding boundaries
            if (r < 55)
                len = $urandom_range(8);
            else if (r < 75)
                len = $urandom_range(68, 52);
            else if (r < 90)
                len = $urandom_range(130);
            else
                len = $urandom_range(130, 118);
            hash_random_message(len);
        end
        // sender pauses until every digest of this phase is out
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_left    = HOLD_CYCLES;
        for (int m = 0; m < 8; m++)
            hash_random_message($urandom_range(2));
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            dig_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            dig_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            dig_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        digest_t want;
        if (rst_n && dig_ch.valid && dig_ch.ready)
        begin
            if (pending_digests.size() == 0)
                report_mismatch("unexpected digest", dig_ch.digest_first_half, 64'h0);
            else
            begin
                want = pending_digests.pop_front();
                if (dig_ch.digest_first_half !== want.first_half)
                    report_mismatch("digest_first_half", dig_ch.digest_first_half,
                                    want.first_half);
                if (dig_ch.digest_second_half !== want.second_half)
                    report_mismatch("digest_second_half", dig_ch.digest_second_half,
                                    want.second_half);
                if (dig_ch.half_mix !== want.half_mix)
                    report_mismatch("half_mix", dig_ch.half_mix, want.half_mix);
                digests_checked++;
            end
        end
    end

    initial
    begin
        int stall_count;
        stall_count = 0;
        while (stall_count < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
                stall_count = 0;
            else
                stall_count++;
        end
        $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("md5_stream_hasher_top test failed");
        $finish;
    end

    initial
    begin
        errors           = 0;
        hold_left        = 0;
        items_sent       = 0;
        bytes_hashed     = 0;
        messages_sent    = 0;
        digests_checked  = 0;
        src_idle_pct     = 12;
        snk_idle_pct     = 69;
        rst_n            = 1'b0;
        msg_ch.valid     = 1'b0;
        msg_ch.data_byte = 8'h00;
        msg_ch.has_byte  = 1'b0;
        msg_ch.is_last   = 1'b0;
        dig_ch.ready     = 1'b0;
        md5_restart();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_messages(12, 69);
        test_random_messages(69, 12);
        test_random_messages(0, 0);
        test_output_backpressure();
        finish_sending();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_digests.size() != 0)
        begin
            $display("%0d digests never arrived", pending_digests.size());
            errors += pending_digests.size();
        end

        $display("Hashed %0d messages (%0d bytes, %0d items), %0d digests checked,",
                 messages_sent, bytes_hashed, items_sent, digests_checked);
        $display("across three idle mixes, padding boundaries and a long output stall.");
        if (errors == 0)
            $display("md5_stream_hasher_top test passed");
        else
            $display("md5_stream_hasher_top test failed");
        $finish;
    end

endmodule
